// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the ring buffer deque RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ----- rtl/core/rbd_pkg.sv -----
// Types, constants and helpers for the ring buffer deque.
// No dependencies; used by rbd_store and ring_buffer_deque_unit.
`default_nettype none

package rbd_pkg;

    // DEPTH must be a power of two so that a slot is the low bits of an index.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int SLOT_W     = $clog2(DEPTH);
    localparam int COUNT_W    = 5;
    localparam int IDX_W      = 32;
    localparam int WORD_W     = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_RIGHT = 3'd0,
        CMD_PUSH_LEFT  = 3'd1,
        CMD_POP_RIGHT  = 3'd2,
        CMD_POP_LEFT   = 3'd3,
        CMD_READ       = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [SLOT_W-1:0] addr;
    } store_req_t;

    // Physical slot of an absolute index: the index modulo DEPTH.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
        return idx[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rbd_store.sv -----
// Element store of the ring buffer deque: one write or one read per cycle,
// read data registered. Depends on rbd_pkg.
`default_nettype none

module rbd_store
    import rbd_pkg::*;
(
    input  wire logic                  clk,
    input  wire store_req_t            req,
    input  wire logic [DATA_WIDTH-1:0] wdata,
    output logic      [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ring_buffer_deque_unit.sv -----
// Ring buffer deque: a double-ended queue in a 16-slot circular store.
//
// Input channel (in_valid / in_stall) carries one command per transfer:
// cmd, value for pushes, signed index for reads. Output channel
// (out_valid / out_stall) returns exactly one result per command:
// read_data, status, count and start_index after the command.
// A push on a full store, a pop on an empty one and a read outside the
// window from start_index to start_index + count - 1 leave the state untouched
// and report their status code.
// Throughput: one command per cycle while in_stall is low. A result passes
// through the pending stage, loaded at the input transfer together with the
// store read, and then through the output register before out_valid rises.
// Counters update at the input transfer, so a read right after a push sees
// the pushed element.
// When out_stall holds the output register, the pending stage fills and then
// in_stall rises; no result is lost or repeated. Reset clears the count, the
// start counter and both valid flags; store contents are not cleared.
// Depends on rbd_pkg, rbd_store and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ring_buffer_deque_unit
    import rbd_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [2:0]                cmd,
    input  wire logic [WORD_W-1:0]         value,
    input  wire logic signed [IDX_W-1:0]   index,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [WORD_W-1:0]              read_data,
    output logic [1:0]                     status,
    output logic [COUNT_W-1:0]             count,
    output logic signed [IDX_W-1:0]        start_index
);

    logic [COUNT_W-1:0]    count_reg,  count_next;
    logic [IDX_W-1:0]      start_reg,  start_next;

    logic                  pend_valid_reg, pend_valid_next;
    status_t               pend_status_reg, pend_status_next;
    logic                  pend_rd_ok_reg, pend_rd_ok_next;
    logic [COUNT_W-1:0]    pend_count_reg;
    logic [IDX_W-1:0]      pend_start_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]     read_data_reg;
    status_t               status_reg;
    logic [COUNT_W-1:0]    count_out_reg;
    logic [IDX_W-1:0]      start_out_reg;

    logic                  in_fire;
    logic                  pend_move;
    logic                  full;
    logic                  empty;
    logic [IDX_W-1:0]      index_u;
    logic [IDX_W-1:0]      offset;
    store_req_t            req;
    logic [DATA_WIDTH-1:0] rdata;

    rbd_store u_store (
        .clk   (clk),
        .req   (req),
        .wdata (value[DATA_WIDTH-1:0]),
        .rdata (rdata)
    );

    assign pend_move = pend_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = pend_valid_reg && !pend_move;
    assign in_fire   = in_valid && !in_stall;

    assign full    = (count_reg >= COUNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign index_u = index;
    assign offset  = index_u - start_reg;

    // Command decode: counters, store access and status
    always_comb
    begin
        count_next       = count_reg;
        start_next       = start_reg;
        pend_status_next = ST_OK;
        pend_rd_ok_next  = 1'b0;
        req.we           = 1'b0;
        req.re           = 1'b0;
        req.addr         = slot_of(index_u);
        if (in_fire)
        begin
            unique case (cmd_t'(cmd))
                CMD_PUSH_RIGHT:
                begin
                    if (full)
                    begin
                        pend_status_next = ST_FULL;
                    end
                    else
                    begin
                        req.we     = 1'b1;
                        req.addr   = slot_of(start_reg + IDX_W'(count_reg));
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_PUSH_LEFT:
                begin
                    if (full)
                    begin
                        pend_status_next = ST_FULL;
                    end
                    else
                    begin
                        req.we     = 1'b1;
                        start_next = start_reg - 1'b1;
                        req.addr   = slot_of(start_reg - 1'b1);
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_POP_RIGHT:
                begin
                    if (empty)
                    begin
                        pend_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                CMD_POP_LEFT:
                begin
                    if (empty)
                    begin
                        pend_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        start_next = start_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                CMD_READ:
                begin
                    if (offset < IDX_W'(count_reg))
                    begin
                        req.re          = 1'b1;
                        pend_rd_ok_next = 1'b1;
                    end
                    else
                    begin
                        pend_status_next = ST_RANGE;
                    end
                end
                default:
                begin
                    pend_status_next = ST_OK;
                end
            endcase
        end
    end

    assign pend_valid_next = in_fire || (pend_valid_reg && !pend_move);
    assign out_valid_next  = pend_move || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            start_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            start_reg      <= start_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Pending stage: holds status and counters while the store read completes
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pend_status_reg <= pend_status_next;
            pend_rd_ok_reg  <= pend_rd_ok_next;
            pend_count_reg  <= count_next;
            pend_start_reg  <= start_next;
        end
    end

    // Output register: advance on pend_move, hold otherwise
    always_ff @(posedge clk)
    begin
        if (pend_move)
        begin
            read_data_reg <= pend_rd_ok_reg ? WORD_W'(rdata) : '0;
            status_reg    <= pend_status_reg;
            count_out_reg <= pend_count_reg;
            start_out_reg <= pend_start_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign status      = status_reg;
    assign count       = count_out_reg;
    assign start_index = start_out_reg;

    `ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > COUNT_W'(DEPTH),
                  "element count above depth")
    `ASSERT_PROP(a_stall_needs_pending, clk, rst_n, in_stall |-> pend_valid_reg && out_valid_reg,
                 "input stalled without a held result")
    `ASSERT_PROP(a_push_counts, clk, rst_n,
                 in_fire && req.we |=> count_reg == $past(count_reg) + 1'b1,
                 "accepted push did not advance count")
    `ASSERT_PROP(a_start_idle, clk, rst_n, !in_fire |=> $stable(start_reg) && $stable(count_reg),
                 "state changed without a command transfer")

endmodule

`default_nettype wire
